@@ rtl/core/qlar_pkg.sv @@
// shared types, constants and arithmetic helpers for the quaternion local-axis rotator
package qlar_pkg;

	localparam int COMP_WIDTH  = 16;
	localparam int FRAC_BITS   = COMP_WIDTH - 2;
	localparam int PROD_W      = 2 * COMP_WIDTH;
	localparam int SUM_W       = PROD_W + 1;
	localparam int ANGLE_W     = 11;
	localparam int AXIS_W      = 2;
	localparam int ANGLE_EXT_W = 12;
	localparam int RANGE_W     = 10;
	localparam int HALF_TURN   = 720;
	localparam int QUARTER     = HALF_TURN / 4;
	localparam int ANGLE_BIAS  = 2 * HALF_TURN;
	localparam int TBL_DEPTH   = QUARTER + 1;
	localparam int TBL_IDX_W   = $clog2(TBL_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TAYLOR_TERMS = 20;

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam logic [63:0] STEP_Q60 = PI_Q60 / 64'd360;

	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;
	localparam int LANE_W = 3;
	localparam int LANES  = 4;

	typedef logic signed [COMP_WIDTH-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	typedef struct packed {
		comp_t sin_v;
		comp_t cos_v;
		axis_t axis;
	} rot_t;

	typedef comp_t sin_tbl_t [TBL_DEPTH];

	localparam comp_t ONE_Q = comp_t'(64'd1 << FRAC_BITS);

	// (a * b) >> 60
	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// unsigned quotient by shift and subtract
	function automatic logic [63:0] udiv_u64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter-wave sine table in half-degree steps, evaluated at elaboration
	function automatic sin_tbl_t build_sin_tbl();
		sin_tbl_t    t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] d;
		for (int k = 0; k < TBL_DEPTH; k++) begin
			x    = STEP_Q60 * 64'(k);
			x2   = mul_q60(x, x);
			term = x;
			s    = x;
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				d    = 64'(2 * n) * 64'(2 * n + 1);
				term = udiv_u64(mul_q60(term, x2), d);
				if ((n % 2) == 1) begin
					s = s - term;
				end else begin
					s = s + term;
				end
			end
			s    = (s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
			t[k] = comp_t'(s);
		end
		return t;
	endfunction

	// round half up to FRAC_BITS fraction bits and saturate to COMP_WIDTH
	function automatic comp_t round_sat(sum_t s);
		logic signed [SUM_W:0]            t;
		logic [SUM_W-FRAC_BITS:0]         v;
		logic [SUM_W-FRAC_BITS-COMP_WIDTH+1:0] hi;
		t  = {s[SUM_W-1], s} + (SUM_W + 1)'(64'd1 << (FRAC_BITS - 1));
		v  = t[SUM_W:FRAC_BITS];
		hi = v[SUM_W-FRAC_BITS:COMP_WIDTH-1];
		if ((&hi) || !(|hi)) begin
			return comp_t'(v[COMP_WIDTH-1:0]);
		end else if (v[SUM_W-FRAC_BITS]) begin
			return {1'b1, {(COMP_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(COMP_WIDTH-1){1'b1}}};
		end
	endfunction

endpackage

@@ rtl/core/qlar_in_if.sv @@
// input channel: rotation angle and axis
interface qlar_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [qlar_pkg::ANGLE_W-1:0]     angle_deg;
	logic        [qlar_pkg::AXIS_W-1:0]      axis;

	modport source (output valid, output angle_deg, output axis, input ready);
	modport sink (input valid, input angle_deg, input axis, output ready);
endinterface

@@ rtl/core/qlar_out_if.sv @@
// output channel: updated orientation quaternion
interface qlar_out_if;
	logic            valid;
	logic            ready;
	qlar_pkg::comp_t quat_x;
	qlar_pkg::comp_t quat_y;
	qlar_pkg::comp_t quat_z;
	qlar_pkg::comp_t quat_w;

	modport source (output valid, output quat_x, output quat_y, output quat_z, output quat_w,
		input ready);
	modport sink (input valid, input quat_x, input quat_y, input quat_z, input quat_w,
		output ready);
endinterface

@@ rtl/core/quaternion_local_axis_rotator.sv @@
// top level of the quaternion local-axis rotator
//
//   channel    direction  fields                          handshake
//   rot_in     in         angle_deg, axis                 valid / ready
//   quat_out   out        quat_x, quat_y, quat_z, quat_w  valid / ready
//
// one transaction per cycle while quat_out is ready; each input is queued, then registered
// the orientation multiply-round-saturate loop closes through orient_q in the back end
// reset puts the orientation to identity and empties the two-entry queue
// a stalled output holds the result and the orientation; the queue absorbs two more inputs
module quaternion_local_axis_rotator (
	input  logic       clk,
	input  logic       arst_n,
	qlar_in_if.sink    rot_in,
	qlar_out_if.source quat_out
);

	logic           push_valid;
	logic           push_ready;
	qlar_pkg::rot_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	qlar_pkg::rot_t pop_data;

	qlar_front u_front (
		.rot_in     (rot_in),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	qlar_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	qlar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.quat_out  (quat_out)
	);

endmodule

@@ rtl/core/qlar_front.sv @@
// front end: angle reduction and sine/cosine table lookup
module qlar_front (
	qlar_in_if.sink          rot_in,
	input  logic             push_ready,
	output logic             push_valid,
	output qlar_pkg::rot_t   push_data
);

	localparam qlar_pkg::sin_tbl_t SIN_TBL = qlar_pkg::build_sin_tbl();

	function automatic qlar_pkg::comp_t sin_lookup(logic [qlar_pkg::RANGE_W-1:0] r);
		logic [qlar_pkg::RANGE_W-1:0] idx;
		logic                         neg;
		qlar_pkg::comp_t              mag;
		if (r <= qlar_pkg::RANGE_W'(qlar_pkg::QUARTER)) begin
			idx = r;
			neg = 1'b0;
		end else if (r <= qlar_pkg::RANGE_W'(2 * qlar_pkg::QUARTER)) begin
			idx = qlar_pkg::RANGE_W'(2 * qlar_pkg::QUARTER) - r;
			neg = 1'b0;
		end else if (r <= qlar_pkg::RANGE_W'(3 * qlar_pkg::QUARTER)) begin
			idx = r - qlar_pkg::RANGE_W'(2 * qlar_pkg::QUARTER);
			neg = 1'b1;
		end else begin
			idx = qlar_pkg::RANGE_W'(qlar_pkg::HALF_TURN) - r;
			neg = 1'b1;
		end
		mag = SIN_TBL[idx[qlar_pkg::TBL_IDX_W-1:0]];
		return neg ? -mag : mag;
	endfunction

	logic [qlar_pkg::ANGLE_EXT_W-1:0] shifted;
	logic [qlar_pkg::RANGE_W-1:0]     r_sin;
	logic [qlar_pkg::RANGE_W:0]       r_cos_sum;
	logic [qlar_pkg::RANGE_W-1:0]     r_cos;

	// half-angle in half-degree steps, reduced modulo a full turn
	always_comb begin
		shifted = qlar_pkg::ANGLE_EXT_W'(int'(rot_in.angle_deg) + qlar_pkg::ANGLE_BIAS);
		if (shifted >= qlar_pkg::ANGLE_EXT_W'(3 * qlar_pkg::HALF_TURN)) begin
			r_sin = qlar_pkg::RANGE_W'(shifted - qlar_pkg::ANGLE_EXT_W'(3 * qlar_pkg::HALF_TURN));
		end else if (shifted >= qlar_pkg::ANGLE_EXT_W'(2 * qlar_pkg::HALF_TURN)) begin
			r_sin = qlar_pkg::RANGE_W'(shifted - qlar_pkg::ANGLE_EXT_W'(2 * qlar_pkg::HALF_TURN));
		end else if (shifted >= qlar_pkg::ANGLE_EXT_W'(qlar_pkg::HALF_TURN)) begin
			r_sin = qlar_pkg::RANGE_W'(shifted - qlar_pkg::ANGLE_EXT_W'(qlar_pkg::HALF_TURN));
		end else begin
			r_sin = qlar_pkg::RANGE_W'(shifted);
		end
		r_cos_sum = {1'b0, r_sin} + (qlar_pkg::RANGE_W + 1)'(qlar_pkg::QUARTER);
		if (r_cos_sum >= (qlar_pkg::RANGE_W + 1)'(qlar_pkg::HALF_TURN)) begin
			r_cos = qlar_pkg::RANGE_W'(r_cos_sum - (qlar_pkg::RANGE_W + 1)'(qlar_pkg::HALF_TURN));
		end else begin
			r_cos = qlar_pkg::RANGE_W'(r_cos_sum);
		end
	end

	assign push_valid      = rot_in.valid;
	assign rot_in.ready    = push_ready;
	assign push_data.sin_v = sin_lookup(r_sin);
	assign push_data.cos_v = sin_lookup(r_cos);
	assign push_data.axis  = qlar_pkg::axis_t'(rot_in.axis);

endmodule

@@ rtl/core/qlar_queue.sv @@
// two-entry queue between front end and back end
module qlar_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  qlar_pkg::rot_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output qlar_pkg::rot_t pop_data
);

	qlar_pkg::rot_t                 entry_q [qlar_pkg::QUEUE_DEPTH];
	logic [qlar_pkg::PTR_W-1:0]     wr_ptr_q;
	logic [qlar_pkg::PTR_W-1:0]     rd_ptr_q;
	logic [qlar_pkg::CNT_W-1:0]     count_q;
	logic                           push_fire;
	logic                           pop_fire;

	assign push_ready = count_q != qlar_pkg::CNT_W'(qlar_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == qlar_pkg::PTR_W'(qlar_pkg::QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + qlar_pkg::PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == qlar_pkg::PTR_W'(qlar_pkg::QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + qlar_pkg::PTR_W'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + qlar_pkg::CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - qlar_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qlar_pkg::CNT_W'(qlar_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && !pop_fire |=> count_q == $past(count_q) + qlar_pkg::CNT_W'(1))
		else $error("queue count did not follow push");

endmodule

@@ rtl/core/qlar_back.sv @@
// back end: hamilton product update of the orientation and result register
module qlar_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  qlar_pkg::rot_t  pop_data,
	qlar_out_if.source      quat_out
);

	qlar_pkg::comp_t orient_q [qlar_pkg::LANES];
	qlar_pkg::comp_t orient_next [qlar_pkg::LANES];
	qlar_pkg::comp_t op [qlar_pkg::LANES];
	logic [qlar_pkg::LANES-1:0] neg;
	qlar_pkg::comp_t sin_eff;
	logic            out_valid_q;
	logic            pop_fire;

	assign pop_ready = !out_valid_q || quat_out.ready;
	assign pop_fire  = pop_valid && pop_ready;

	// partner component and sign of the sine term for each lane
	always_comb begin
		sin_eff = pop_data.sin_v;
		op      = '{default: '0};
		neg     = '0;
		case (pop_data.axis)
			qlar_pkg::AXIS_X: begin
				op[qlar_pkg::LANE_X]  = orient_q[qlar_pkg::LANE_W];
				op[qlar_pkg::LANE_Y]  = orient_q[qlar_pkg::LANE_Z];
				op[qlar_pkg::LANE_Z]  = orient_q[qlar_pkg::LANE_Y];
				neg[qlar_pkg::LANE_Z] = 1'b1;
				op[qlar_pkg::LANE_W]  = orient_q[qlar_pkg::LANE_X];
				neg[qlar_pkg::LANE_W] = 1'b1;
			end
			qlar_pkg::AXIS_Y: begin
				op[qlar_pkg::LANE_X]  = orient_q[qlar_pkg::LANE_Z];
				neg[qlar_pkg::LANE_X] = 1'b1;
				op[qlar_pkg::LANE_Y]  = orient_q[qlar_pkg::LANE_W];
				op[qlar_pkg::LANE_Z]  = orient_q[qlar_pkg::LANE_X];
				op[qlar_pkg::LANE_W]  = orient_q[qlar_pkg::LANE_Y];
				neg[qlar_pkg::LANE_W] = 1'b1;
			end
			qlar_pkg::AXIS_Z: begin
				op[qlar_pkg::LANE_X]  = orient_q[qlar_pkg::LANE_Y];
				op[qlar_pkg::LANE_Y]  = orient_q[qlar_pkg::LANE_X];
				neg[qlar_pkg::LANE_Y] = 1'b1;
				op[qlar_pkg::LANE_Z]  = orient_q[qlar_pkg::LANE_W];
				op[qlar_pkg::LANE_W]  = orient_q[qlar_pkg::LANE_Z];
				neg[qlar_pkg::LANE_W] = 1'b1;
			end
			default: begin
				sin_eff = '0;
			end
		endcase
	end

	for (genvar i = 0; i < qlar_pkg::LANES; i++) begin : g_lane
		qlar_pkg::prod_t prod_c;
		qlar_pkg::prod_t prod_s;
		qlar_pkg::sum_t  sum;

		assign prod_c = orient_q[i] * pop_data.cos_v;
		assign prod_s = op[i] * sin_eff;
		assign sum    = neg[i] ? qlar_pkg::sum_t'(prod_c) - qlar_pkg::sum_t'(prod_s) :
			qlar_pkg::sum_t'(prod_c) + qlar_pkg::sum_t'(prod_s);
		assign orient_next[i] = qlar_pkg::round_sat(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q[qlar_pkg::LANE_X] <= '0;
			orient_q[qlar_pkg::LANE_Y] <= '0;
			orient_q[qlar_pkg::LANE_Z] <= '0;
			orient_q[qlar_pkg::LANE_W] <= qlar_pkg::ONE_Q;
			out_valid_q                <= 1'b0;
		end else begin
			if (pop_fire) begin
				orient_q    <= orient_next;
				out_valid_q <= 1'b1;
			end else if (quat_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign quat_out.valid  = out_valid_q;
	assign quat_out.quat_x = orient_q[qlar_pkg::LANE_X];
	assign quat_out.quat_y = orient_q[qlar_pkg::LANE_Y];
	assign quat_out.quat_z = orient_q[qlar_pkg::LANE_Z];
	assign quat_out.quat_w = orient_q[qlar_pkg::LANE_W];

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |=> out_valid_q)
		else $error("update not presented");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !quat_out.ready |=> out_valid_q && $stable(orient_q[qlar_pkg::LANE_W])
		&& $stable(orient_q[qlar_pkg::LANE_X]))
		else $error("orientation changed while result stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && quat_out.ready && !pop_fire |=> !out_valid_q)
		else $error("result repeated");

endmodule
